// File: design/owtsr_pkg.sv
// Shared types, codes and constants for the one-wire temperature reader.
`timescale 1ns / 1ps

package owtsr_pkg;

  localparam int unsigned READ_BITS_DEFAULT    = 16;
  localparam int unsigned COUNTER_BITS_DEFAULT = 24;

  localparam int unsigned READING_W  = 16;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 4;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RELEASE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_START   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_START    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVER  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT  = 4'd7;

  // Register reset values.
  localparam logic [15:0] RESET_LOW_INIT     = 16'd500;
  localparam logic [15:0] RESET_RELEASE_INIT = 16'd500;
  localparam logic [15:0] WRITE_START_INIT   = 16'd2;
  localparam logic [15:0] WRITE_HOLD_INIT    = 16'd60;
  localparam logic [15:0] READ_START_INIT    = 16'd2;
  localparam logic [15:0] READ_SAMPLE_INIT   = 16'd8;
  localparam logic [15:0] READ_RECOVER_INIT  = 16'd12;
  localparam logic [23:0] CONVERT_WAIT_INIT  = 24'd100;

  // Command bytes sent by the program.
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // Slot phases.
  localparam logic [1:0] PHASE_LOW     = 2'd0;
  localparam logic [1:0] PHASE_SECOND  = 2'd1;
  localparam logic [1:0] PHASE_RECOVER = 2'd2;

  typedef enum logic [3:0] {
    STEP_IDLE  = 4'd0,
    STEP_RST1  = 4'd1,
    STEP_SKIP1 = 4'd2,
    STEP_CONV  = 4'd3,
    STEP_WAIT  = 4'd4,
    STEP_RST2  = 4'd5,
    STEP_SKIP2 = 4'd6,
    STEP_RDCMD = 4'd7,
    STEP_READ  = 4'd8
  } step_e;

  typedef struct packed {
    logic [15:0] reset_low;
    logic [15:0] reset_release;
    logic [15:0] write_start;
    logic [15:0] write_hold;
    logic [15:0] read_start;
    logic [15:0] read_sample;
    logic [15:0] read_recover;
    logic [23:0] convert_wait;
  } cfg_t;

  typedef struct packed {
    logic signed [READING_W-1:0] temperature;
    logic                        done;
    logic                        busy;
    logic                        drive_level;
    logic                        drive_enable;
  } result_t;

endpackage

// File: design/owtsr_sequencer.sv
// Bus program sequencer: one tick per accepted item, result computed in the same cycle.
`timescale 1ns / 1ps

module owtsr_sequencer #(
  parameter int unsigned READ_BITS    = owtsr_pkg::READ_BITS_DEFAULT,
  parameter int unsigned COUNTER_BITS = owtsr_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                start_req_i,
  input  logic                line_level_i,
  input  owtsr_pkg::cfg_t     cfg_i,
  output owtsr_pkg::result_t  result_o
);

  localparam int unsigned WIDE_W = (COUNTER_BITS > 24) ? COUNTER_BITS : 24;

  // Last counter value of a phase: zero acts as one, long spans clip to the counter range.
  function automatic logic [COUNTER_BITS-1:0] span_last(input logic [23:0] v);
    logic [WIDE_W-1:0] m;
    m = WIDE_W'(v) - WIDE_W'(1);
    if (v == 24'd0) begin
      m = '0;
    end else if (m > WIDE_W'({COUNTER_BITS{1'b1}})) begin
      m = WIDE_W'({COUNTER_BITS{1'b1}});
    end
    return m[COUNTER_BITS-1:0];
  endfunction

  owtsr_pkg::step_e          step_q, step_d, eff_step;
  logic [1:0]                phase_q, phase_d, eff_phase;
  logic [4:0]                bit_q, bit_d, eff_bit, bit_inc;
  logic [COUNTER_BITS-1:0]   tick_q, tick_d, eff_tick, last_tick;
  logic [7:0]                send_q, send_d;
  logic [15:0]               rshift_q, rshift_d;
  logic [15:0]               reading_q, reading_d;
  logic [23:0]               span_v;
  logic [15:0]               aligned, mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= owtsr_pkg::STEP_IDLE;
      phase_q   <= owtsr_pkg::PHASE_LOW;
      bit_q     <= '0;
      tick_q    <= '0;
      send_q    <= '0;
      rshift_q  <= '0;
      reading_q <= '0;
    end else if (tick_i) begin
      step_q    <= step_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
      send_q    <= send_d;
      rshift_q  <= rshift_d;
      reading_q <= reading_d;
    end
  end

  always_comb begin
    eff_step  = step_q;
    eff_phase = phase_q;
    eff_bit   = bit_q;
    eff_tick  = tick_q;
    // A start seen while idle makes this tick the first tick of the reset pulse.
    if (step_q == owtsr_pkg::STEP_IDLE && start_req_i) begin
      eff_step  = owtsr_pkg::STEP_RST1;
      eff_phase = owtsr_pkg::PHASE_LOW;
      eff_bit   = '0;
      eff_tick  = '0;
    end

    unique case (eff_step)
      owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2:
        span_v = (eff_phase == owtsr_pkg::PHASE_LOW) ? 24'(cfg_i.reset_low)
                                                     : 24'(cfg_i.reset_release);
      owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
      owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD:
        span_v = (eff_phase == owtsr_pkg::PHASE_LOW) ? 24'(cfg_i.write_start)
                                                     : 24'(cfg_i.write_hold);
      owtsr_pkg::STEP_READ:
        span_v = (eff_phase == owtsr_pkg::PHASE_LOW)    ? 24'(cfg_i.read_start) :
                 (eff_phase == owtsr_pkg::PHASE_SECOND) ? 24'(cfg_i.read_sample) :
                                                          24'(cfg_i.read_recover);
      default:
        span_v = cfg_i.convert_wait;
    endcase
    last_tick = span_last(span_v);

    step_d    = eff_step;
    phase_d   = eff_phase;
    bit_d     = eff_bit;
    tick_d    = eff_tick;
    send_d    = send_q;
    rshift_d  = rshift_q;
    reading_d = reading_q;
    bit_inc   = eff_bit + 5'd1;
    aligned   = '0;
    mask      = 16'((32'd1 << READ_BITS) - 32'd1);

    result_o = '0;

    if (eff_step != owtsr_pkg::STEP_IDLE) begin
      result_o.busy = 1'b1;
      unique case (eff_step)
        owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2: begin
          result_o.drive_enable = (eff_phase == owtsr_pkg::PHASE_LOW);
        end
        owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
        owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD: begin
          result_o.drive_enable = 1'b1;
          result_o.drive_level  = (eff_phase == owtsr_pkg::PHASE_LOW) ? 1'b0 : send_q[0];
        end
        owtsr_pkg::STEP_READ: begin
          result_o.drive_enable = (eff_phase == owtsr_pkg::PHASE_LOW);
          // Sample on the first tick of the recover phase, shifting in at the top.
          if (eff_phase == owtsr_pkg::PHASE_RECOVER && eff_tick == '0) begin
            rshift_d = {line_level_i, rshift_q[15:1]};
          end
        end
        default: begin
        end
      endcase

      if (eff_tick >= last_tick) begin
        tick_d = '0;
        unique case (eff_step)
          owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2: begin
            if (eff_phase == owtsr_pkg::PHASE_LOW) begin
              phase_d = owtsr_pkg::PHASE_SECOND;
            end else begin
              step_d  = (eff_step == owtsr_pkg::STEP_RST1) ? owtsr_pkg::STEP_SKIP1
                                                           : owtsr_pkg::STEP_SKIP2;
              send_d  = owtsr_pkg::CMD_SKIP_ROM;
              bit_d   = '0;
              phase_d = owtsr_pkg::PHASE_LOW;
            end
          end
          owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
          owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD: begin
            if (eff_phase == owtsr_pkg::PHASE_LOW) begin
              phase_d = owtsr_pkg::PHASE_SECOND;
            end else begin
              send_d  = {1'b0, send_q[7:1]};
              bit_d   = bit_inc;
              phase_d = owtsr_pkg::PHASE_LOW;
              if (bit_inc >= 5'd8) begin
                bit_d = '0;
                unique case (eff_step)
                  owtsr_pkg::STEP_SKIP1: begin
                    step_d = owtsr_pkg::STEP_CONV;
                    send_d = owtsr_pkg::CMD_CONVERT;
                  end
                  owtsr_pkg::STEP_SKIP2: begin
                    step_d = owtsr_pkg::STEP_RDCMD;
                    send_d = owtsr_pkg::CMD_READ_SCRATCH;
                  end
                  owtsr_pkg::STEP_CONV: begin
                    step_d = owtsr_pkg::STEP_WAIT;
                  end
                  default: begin
                    step_d   = owtsr_pkg::STEP_READ;
                    rshift_d = '0;
                  end
                endcase
              end
            end
          end
          owtsr_pkg::STEP_WAIT: begin
            step_d  = owtsr_pkg::STEP_RST2;
            phase_d = owtsr_pkg::PHASE_LOW;
          end
          owtsr_pkg::STEP_READ: begin
            if (eff_phase != owtsr_pkg::PHASE_RECOVER) begin
              phase_d = eff_phase + 2'd1;
            end else begin
              phase_d = owtsr_pkg::PHASE_LOW;
              bit_d   = bit_inc;
              if (bit_inc >= 5'(READ_BITS)) begin
                // Right-align the gathered bits and sign-extend from the top read bit.
                aligned   = rshift_d >> (16 - READ_BITS);
                reading_d = aligned[READ_BITS-1] ? (aligned | ~mask) : (aligned & mask);
                step_d    = owtsr_pkg::STEP_IDLE;
                bit_d     = '0;
                result_o.done = 1'b1;
              end
            end
          end
          default: begin
            step_d  = owtsr_pkg::STEP_IDLE;
            phase_d = owtsr_pkg::PHASE_LOW;
            bit_d   = '0;
          end
        endcase
      end else begin
        tick_d = eff_tick + COUNTER_BITS'(1);
      end
    end

    result_o.temperature = reading_d;
  end

endmodule

// File: design/one_wire_temp_sensor_reader_top.sv
// Top level of the one-wire temperature reader: config registers, sequencer and output buffer.
`timescale 1ns / 1ps

// Each transaction on the slave stream is one bus tick. It carries a start request and the
// sampled bus level. For every tick the master stream returns exactly one transaction with the
// pin drive enable and level, busy, a one-tick done strobe and the last signed reading in
// sixteenths of a degree. A start while idle runs the full program: reset pulse, skip-ROM,
// convert, conversion wait, second reset pulse, skip-ROM, read-scratchpad and the read slots.
// Throughput is one tick per clock cycle while the skid register is empty. The sequencer
// computes the result of a tick in the cycle the tick is accepted and registers it in the output
// buffer. A two-entry output buffer (output register plus skid register) lets the slave side keep
// accepting while a result waits; when the receiver stalls, the buffer fills and s_axis_tready
// drops until it drains, and the sequencer state simply holds.
// The configuration channel is always ready and writes one timing register per transaction;
// writes to indexes above seven are dropped. Configuration is meant to change only while idle.
// Reset clears the program to idle, empties the output buffer, sets the reading to zero and
// loads the default timing values.

module one_wire_temp_sensor_reader_top #(
  parameter int unsigned READ_BITS    = owtsr_pkg::READ_BITS_DEFAULT,
  parameter int unsigned COUNTER_BITS = owtsr_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: start_req, line_level, zero fill.
  input  logic [7:0]                         s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: pin_drive_enable, pin_drive_level, busy_res, done_res,
  // temperature[15:0], zero fill.
  output logic [23:0]                        m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [owtsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [owtsr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  owtsr_pkg::cfg_t    cfg_q;
  owtsr_pkg::result_t result;
  owtsr_pkg::result_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               accept, pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  // Timing registers; each write keeps only the width of its register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= owtsr_pkg::RESET_LOW_INIT;
      cfg_q.reset_release <= owtsr_pkg::RESET_RELEASE_INIT;
      cfg_q.write_start   <= owtsr_pkg::WRITE_START_INIT;
      cfg_q.write_hold    <= owtsr_pkg::WRITE_HOLD_INIT;
      cfg_q.read_start    <= owtsr_pkg::READ_START_INIT;
      cfg_q.read_sample   <= owtsr_pkg::READ_SAMPLE_INIT;
      cfg_q.read_recover  <= owtsr_pkg::READ_RECOVER_INIT;
      cfg_q.convert_wait  <= owtsr_pkg::CONVERT_WAIT_INIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        owtsr_pkg::CFG_RESET_LOW:     cfg_q.reset_low     <= cfg_data_i[15:0];
        owtsr_pkg::CFG_RESET_RELEASE: cfg_q.reset_release <= cfg_data_i[15:0];
        owtsr_pkg::CFG_WRITE_START:   cfg_q.write_start   <= cfg_data_i[15:0];
        owtsr_pkg::CFG_WRITE_HOLD:    cfg_q.write_hold    <= cfg_data_i[15:0];
        owtsr_pkg::CFG_READ_START:    cfg_q.read_start    <= cfg_data_i[15:0];
        owtsr_pkg::CFG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data_i[15:0];
        owtsr_pkg::CFG_READ_RECOVER:  cfg_q.read_recover  <= cfg_data_i[15:0];
        owtsr_pkg::CFG_CONVERT_WAIT:  cfg_q.convert_wait  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  owtsr_sequencer #(
    .READ_BITS    (READ_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_sequencer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (accept),
    .start_req_i  (s_axis_tdata[0]),
    .line_level_i (s_axis_tdata[1]),
    .cfg_i        (cfg_q),
    .result_o     (result)
  );

  // Output register with a skid register behind it. Results leave in tick order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= result;
        end
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.temperature, out_q.done, out_q.busy,
                          out_q.drive_level, out_q.drive_enable};

endmodule

// File: verif/one_wire_temp_sensor_reader_top_tb.sv
// Self-checking testbench for the one-wire temperature reader top level.
`timescale 1ns / 1ps

// Predicts the result of each bus tick and checks the results in the order they come out.
class tick_scoreboard;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned NUM_READ_BITS = owtsr_pkg::READ_BITS_DEFAULT;

  logic [23:0]          timing [8];
  owtsr_pkg::step_e     step;
  logic [1:0]           phase;
  logic [4:0]           bit_cnt;
  logic [23:0]          tick_cnt;
  logic [7:0]           cmd_shift;
  logic [15:0]          sample_shift;
  logic [15:0]          reading;

  owtsr_pkg::result_t   pending_outputs [$];
  int unsigned          errors;
  int unsigned          ticks;
  int unsigned          readings;

  function new();
    timing[owtsr_pkg::CFG_RESET_LOW]     = {8'h00, owtsr_pkg::RESET_LOW_INIT};
    timing[owtsr_pkg::CFG_RESET_RELEASE] = {8'h00, owtsr_pkg::RESET_RELEASE_INIT};
    timing[owtsr_pkg::CFG_WRITE_START]   = {8'h00, owtsr_pkg::WRITE_START_INIT};
    timing[owtsr_pkg::CFG_WRITE_HOLD]    = {8'h00, owtsr_pkg::WRITE_HOLD_INIT};
    timing[owtsr_pkg::CFG_READ_START]    = {8'h00, owtsr_pkg::READ_START_INIT};
    timing[owtsr_pkg::CFG_READ_SAMPLE]   = {8'h00, owtsr_pkg::READ_SAMPLE_INIT};
    timing[owtsr_pkg::CFG_READ_RECOVER]  = {8'h00, owtsr_pkg::READ_RECOVER_INIT};
    timing[owtsr_pkg::CFG_CONVERT_WAIT]  = owtsr_pkg::CONVERT_WAIT_INIT;
    step         = owtsr_pkg::STEP_IDLE;
    phase        = owtsr_pkg::PHASE_LOW;
    bit_cnt      = '0;
    tick_cnt     = '0;
    cmd_shift    = '0;
    sample_shift = '0;
    reading      = '0;
    errors       = 0;
    ticks        = 0;
    readings     = 0;
  endfunction

  // Writes to indexes past the last register are dropped by the block.
  function void load_timing(logic [owtsr_pkg::CFG_IDX_W-1:0] idx,
                            logic [owtsr_pkg::CFG_DATA_W-1:0] data);
    if (idx <= owtsr_pkg::CFG_CONVERT_WAIT) begin
      timing[idx] = (idx == owtsr_pkg::CFG_CONVERT_WAIT) ? data : {8'h00, data[15:0]};
    end
  endfunction

  function void load_cmd(owtsr_pkg::step_e next_step, logic [7:0] cmd);
    step      = next_step;
    cmd_shift = cmd;
    bit_cnt   = '0;
    phase     = owtsr_pkg::PHASE_LOW;
  endfunction

  // A duration of zero still lasts one tick.
  function int unsigned phase_len();
    int unsigned v;
    case (step)
      owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2: begin
        v = (phase == owtsr_pkg::PHASE_LOW) ? timing[owtsr_pkg::CFG_RESET_LOW]
                                            : timing[owtsr_pkg::CFG_RESET_RELEASE];
      end
      owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
      owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD: begin
        v = (phase == owtsr_pkg::PHASE_LOW) ? timing[owtsr_pkg::CFG_WRITE_START]
                                            : timing[owtsr_pkg::CFG_WRITE_HOLD];
      end
      owtsr_pkg::STEP_READ: begin
        if (phase == owtsr_pkg::PHASE_LOW) v = timing[owtsr_pkg::CFG_READ_START];
        else if (phase == owtsr_pkg::PHASE_SECOND) v = timing[owtsr_pkg::CFG_READ_SAMPLE];
        else v = timing[owtsr_pkg::CFG_READ_RECOVER];
      end
      default: v = timing[owtsr_pkg::CFG_CONVERT_WAIT];
    endcase
    return (v == 0) ? 1 : v;
  endfunction

  // Steps to the next phase of the program; returns 1 when the reading is complete.
  function logic advance();
    logic [15:0] keep;
    logic [15:0] value;
    tick_cnt = '0;
    case (step)
      owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2: begin
        if (phase == owtsr_pkg::PHASE_LOW) phase = owtsr_pkg::PHASE_SECOND;
        else if (step == owtsr_pkg::STEP_RST1)
          load_cmd(owtsr_pkg::STEP_SKIP1, owtsr_pkg::CMD_SKIP_ROM);
        else load_cmd(owtsr_pkg::STEP_SKIP2, owtsr_pkg::CMD_SKIP_ROM);
      end
      owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
      owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD: begin
        if (phase == owtsr_pkg::PHASE_LOW) begin
          phase = owtsr_pkg::PHASE_SECOND;
        end else begin
          cmd_shift = cmd_shift >> 1;
          bit_cnt   = bit_cnt + 1'b1;
          phase     = owtsr_pkg::PHASE_LOW;
          if (bit_cnt == BYTE_BITS) begin
            case (step)
              owtsr_pkg::STEP_SKIP1: load_cmd(owtsr_pkg::STEP_CONV, owtsr_pkg::CMD_CONVERT);
              owtsr_pkg::STEP_SKIP2:
                load_cmd(owtsr_pkg::STEP_RDCMD, owtsr_pkg::CMD_READ_SCRATCH);
              owtsr_pkg::STEP_CONV: begin
                step    = owtsr_pkg::STEP_WAIT;
                bit_cnt = '0;
              end
              default: begin
                step         = owtsr_pkg::STEP_READ;
                bit_cnt      = '0;
                sample_shift = '0;
              end
            endcase
          end
        end
      end
      owtsr_pkg::STEP_WAIT: begin
        step  = owtsr_pkg::STEP_RST2;
        phase = owtsr_pkg::PHASE_LOW;
      end
      owtsr_pkg::STEP_READ: begin
        if (phase != owtsr_pkg::PHASE_RECOVER) begin
          phase = phase + 1'b1;
        end else begin
          phase   = owtsr_pkg::PHASE_LOW;
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt == NUM_READ_BITS) begin
            // Right-align the gathered bits and sign-extend from the top read bit.
            keep  = 16'((17'(1) << NUM_READ_BITS) - 1);
            value = (sample_shift >> (owtsr_pkg::READING_W - NUM_READ_BITS)) & keep;
            if (value[NUM_READ_BITS-1]) value = value | ~keep;
            reading = value;
            step    = owtsr_pkg::STEP_IDLE;
            bit_cnt = '0;
            return 1'b1;
          end
        end
      end
      default: begin
        step    = owtsr_pkg::STEP_IDLE;
        phase   = owtsr_pkg::PHASE_LOW;
        bit_cnt = '0;
      end
    endcase
    return 1'b0;
  endfunction

  // Called for every accepted tick: runs the sequencer one tick and queues its result.
  function void take_tick(logic start, logic level);
    owtsr_pkg::result_t res;
    res = '0;
    ticks++;
    if (step == owtsr_pkg::STEP_IDLE && start) begin
      step     = owtsr_pkg::STEP_RST1;
      phase    = owtsr_pkg::PHASE_LOW;
      bit_cnt  = '0;
      tick_cnt = '0;
    end
    if (step != owtsr_pkg::STEP_IDLE) begin
      res.busy = 1'b1;
      case (step)
        owtsr_pkg::STEP_RST1, owtsr_pkg::STEP_RST2:
          res.drive_enable = (phase == owtsr_pkg::PHASE_LOW);
        owtsr_pkg::STEP_SKIP1, owtsr_pkg::STEP_CONV,
        owtsr_pkg::STEP_SKIP2, owtsr_pkg::STEP_RDCMD: begin
          res.drive_enable = 1'b1;
          res.drive_level  = (phase == owtsr_pkg::PHASE_LOW) ? 1'b0 : cmd_shift[0];
        end
        owtsr_pkg::STEP_READ: begin
          res.drive_enable = (phase == owtsr_pkg::PHASE_LOW);
          // The bus is sampled on the first tick of the recover phase.
          if (phase == owtsr_pkg::PHASE_RECOVER && tick_cnt == 0) begin
            sample_shift = {level, sample_shift[15:1]};
          end
        end
        default: ;
      endcase
      if (32'(tick_cnt) + 1 >= phase_len()) begin
        res.done = advance();
        if (res.done) readings++;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end
    res.temperature = reading;
    pending_outputs.push_back(res);
  endfunction

  function void compare(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_output(logic [23:0] data);
    owtsr_pkg::result_t got;
    owtsr_pkg::result_t want;
    got = data[$bits(owtsr_pkg::result_t)-1:0];
    if (pending_outputs.size() == 0) begin
      $error("result transaction arrived with no tick waiting for it");
      errors++;
      return;
    end
    want = pending_outputs.pop_front();
    compare("pin_drive_enable", want.drive_enable, got.drive_enable);
    compare("pin_drive_level", want.drive_level, got.drive_level);
    compare("busy_res", want.busy, got.busy);
    compare("done_res", want.done, got.done);
    compare("temperature", $signed(want.temperature), $signed(got.temperature));
  endfunction
endclass

module one_wire_temp_sensor_reader_top_tb;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned CFG_IDX_W      = owtsr_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W     = owtsr_pkg::CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] TIMING_IDX [8] = '{
    owtsr_pkg::CFG_RESET_LOW, owtsr_pkg::CFG_RESET_RELEASE,
    owtsr_pkg::CFG_WRITE_START, owtsr_pkg::CFG_WRITE_HOLD,
    owtsr_pkg::CFG_READ_START, owtsr_pkg::CFG_READ_SAMPLE,
    owtsr_pkg::CFG_READ_RECOVER, owtsr_pkg::CFG_CONVERT_WAIT
  };

  // Readings at the edges of the signed range and single-bit corners.
  localparam logic [15:0] CORNER_READINGS [5] = '{
    16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [23:0]           m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  tick_scoreboard sb = new();

  logic        quiet       = 1'b0;  // no idling on either side in the last part
  logic        gaps_on     = 1'b1;
  logic        rx_calm     = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned stuck_cycles = 0;
  int unsigned settings_applied = 0;

  one_wire_temp_sensor_reader_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver back-pressure: random stalls, with calm stretches in between.
  always @(posedge clk_i) begin
    if (quiet || rx_calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 255) == 0) rx_calm <= !rx_calm;
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Sends one bus tick and feeds it to the predictor once it is accepted.
  task automatic send_tick(input logic start, input logic level);
    s_axis_tdata  <= {6'b0, level, start};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_tick(start, level);
    if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stops the tick stream and waits until every predicted result has been seen.
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all eight timing registers, then one write to an unused index.
  task automatic apply_timing(input logic [23:0] setting [8]);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    drain();
    for (int i = 0; i < 9; i++) begin
      if (i < 8) begin
        idx  = TIMING_IDX[i];
        data = setting[i];
      end else begin
        idx  = owtsr_pkg::CFG_CONVERT_WAIT + CFG_IDX_W'($urandom_range(1, 8));
        data = CFG_DATA_W'($urandom);
      end
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.load_timing(idx, data);
    end
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  // Short timings keep programs fast; the unused upper bits of the 16-bit registers are noise.
  task automatic make_short_setting(output logic [23:0] setting [8]);
    for (int i = 0; i < 7; i++) begin
      setting[i] = {8'($urandom), 16'($urandom_range(0, ($urandom_range(0, 5) == 0) ? 7 : 3))};
    end
    setting[7] = 24'($urandom_range(0, 30));
  endtask

  // Runs one complete temperature read. During the read slots the bus carries the
  // bits of the wanted reading; elsewhere the bus level and further starts are random.
  task automatic run_reading(input logic [15:0] wanted);
    int unsigned seen;
    logic        level;
    seen    = sb.readings;
    gaps_on = ($urandom_range(0, 2) != 0);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (sb.readings == seen) begin
      if (sb.step == owtsr_pkg::STEP_READ) level = wanted[sb.bit_cnt[3:0]];
      else level = 1'($urandom_range(0, 1));
      send_tick(1'($urandom_range(0, 1)), level);
    end
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [15:0] pick_reading();
    if ($urandom_range(0, 3) == 0) return CORNER_READINGS[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  initial begin
    logic [23:0] setting [8];

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default timing straight out of reset: idle ticks with both bus levels.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Every register at zero behaves as one tick; go through all corner readings.
    foreach (setting[i]) setting[i] = '0;
    apply_timing(setting);
    foreach (CORNER_READINGS[k]) run_reading(CORNER_READINGS[k]);

    // Random short timings.
    make_short_setting(setting);
    apply_timing(setting);
    run_reading(pick_reading());

    // All registers at their maximum; only idle ticks, which must leave the bus alone.
    foreach (setting[i]) setting[i] = 24'hFFFFFF;
    apply_timing(setting);
    repeat (20) send_tick(1'b0, 1'($urandom_range(0, 1)));

    // Last part without any idling on either side.
    quiet = 1'b1;
    make_short_setting(setting);
    apply_timing(setting);
    run_reading(pick_reading());

    drain();
    $display("Run covered %0d bus ticks and %0d completed readings.", sb.ticks, sb.readings);
    $display("Timing was reprogrammed %0d times, from all-zero up to all-ones.",
             settings_applied);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/owtsr_pkg.sv
design/owtsr_sequencer.sv
design/one_wire_temp_sensor_reader_top.sv
verif/one_wire_temp_sensor_reader_top_tb.sv
